### src/rbb_pkg.sv
// Renko brick builder: shared constants, result record type and a helper function.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package rbb_pkg;

   localparam int PRICE_WIDTH_DEF = 32;
   localparam int PRICE_BITS      = 32;
   localparam int TIME_BITS       = 64;
   localparam int FRAC_BITS       = 16;
   localparam int COUNT_BITS      = 16;
   localparam int REQ_TDATA_W     = 96;
   localparam int RSP_TDATA_W     = 200;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [31:0] BRICK_SIZE_RST = 32'd100;
   localparam logic [15:0] MAX_BRICKS_RST = 16'd1000;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_BRICK_SIZE = 1'b0;
   localparam logic CSR_IDX_MAX_BRICKS = 1'b1;

   // recent direction history, bit 0 newest, 1 = up
   localparam logic [2:0]  DIR_UDU     = 3'b101;
   localparam logic [2:0]  DIR_DUD     = 3'b010;
   localparam logic [15:0] PATTERN_MIN = 16'd3;

   typedef struct packed {
      logic        brick_formed;
      logic        brick_up;
      logic [31:0] brick_close;
      logic [63:0] brick_time;
      logic        forming_up;
      logic [15:0] completion;
      logic [15:0] up_run;
      logic [15:0] down_run;
      logic        up_down_up;
      logic        down_up_down;
      logic [15:0] bricks_held;
      logic [31:0] reference_out;
   } rsp_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic [15:0] lim);
      logic [16:0] n;
      n = {1'b0, v} + 17'd1;
      return (n > {1'b0, lim}) ? lim : n[15:0];
   endfunction

endpackage

### src/renko_brick_builder.sv
// Renko brick builder top level: register block, tick front end and brick back end.
// Depends on rbb_pkg, rbb_csr, rbb_front and rbb_back.
`timescale 1ns / 1ps

// Usage:
//   req_* carries price ticks; a tick with zero price is taken and dropped.
//   rsp_* carries one result request per non-zero tick, in tick order.
//   csr_* sets brick_size (0x0) and max_bricks (0x4); write only while idle.
// Path: a tick that sets the reference or closes a brick goes from the queue
//   straight into the result register; a tick inside the current brick runs the
//   serial fraction unit before its result is loaded into the result register.
// Throughput: one tick per cycle for brick closures while the result register
//   is free; partial bricks wait for the 16-step fraction divider to finish.
// A two-entry queue sits between front and back, so req_tready stays high
//   while the back end is busy until that queue is full.
// Reset clears the reference, the started flag, all counts and history, and
//   restores brick_size 100 and max_bricks 1000.
// When rsp_tready is low the result register holds its request; the back end
//   stops before loading a new result, then the queue fills and req_tready drops.

module renko_brick_builder #(
   parameter int PRICE_WIDTH = rbb_pkg::PRICE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rbb_pkg::REQ_TDATA_W-1:0]   req_tdata,   // price[31:0], tick_time[95:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // brick_up[0], brick_close[32:1], brick_time[96:33], forming_up[97],
   // completion[113:98], up_run[129:114], down_run[145:130], up_down_up[146],
   // down_up_down[147], bricks_held[163:148], reference_out[195:164], zero fill
   output logic [rbb_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,   // brick_formed
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [31:0]            brick_size;
   logic [15:0]            max_bricks;
   logic                   q_valid;
   logic [PRICE_WIDTH-1:0] q_price;
   logic [63:0]            q_time;
   logic                   q_pop;
   rbb_pkg::rsp_type       rsp_data;

   rbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .brick_size  (brick_size),
      .max_bricks  (max_bricks)
   );

   rbb_front #(.PRICE_WIDTH(PRICE_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_price    (q_price),
      .q_time     (q_time),
      .q_pop      (q_pop)
   );

   rbb_back #(.PRICE_WIDTH(PRICE_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .brick_size (brick_size),
      .max_bricks (max_bricks),
      .q_valid    (q_valid),
      .q_price    (q_price),
      .q_time     (q_time),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.brick_formed;
   assign rsp_tdata = {4'd0,
                       rsp_data.reference_out,
                       rsp_data.bricks_held,
                       rsp_data.down_up_down,
                       rsp_data.up_down_up,
                       rsp_data.down_run,
                       rsp_data.up_run,
                       rsp_data.completion,
                       rsp_data.forming_up,
                       rsp_data.brick_time,
                       rsp_data.brick_close,
                       rsp_data.brick_up};

endmodule

### src/rbb_csr.sv
// Renko brick builder: APB-style register block (brick_size, max_bricks).
// Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [31:0]                       brick_size,
   output logic [15:0]                       max_bricks
);

   logic [31:0] brick_size_ff, brick_size_in;
   logic [15:0] max_bricks_ff, max_bricks_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      brick_size_in = brick_size_ff;
      max_bricks_in = max_bricks_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            rbb_pkg::CSR_IDX_BRICK_SIZE: brick_size_in = csr_pwdata;
            rbb_pkg::CSR_IDX_MAX_BRICKS: max_bricks_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         rbb_pkg::CSR_IDX_BRICK_SIZE: csr_prdata = brick_size_ff;
         rbb_pkg::CSR_IDX_MAX_BRICKS: csr_prdata = {16'd0, max_bricks_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brick_size_ff <= rbb_pkg::BRICK_SIZE_RST;
         max_bricks_ff <= rbb_pkg::MAX_BRICKS_RST;
      end else begin
         brick_size_ff <= brick_size_in;
         max_bricks_ff <= max_bricks_in;
      end
   end

   assign brick_size = brick_size_ff;
   assign max_bricks = max_bricks_ff;

endmodule

### src/rbb_front.sv
// Renko brick builder front end: accepts ticks, drops zero prices and queues
// the rest in a two-entry queue for the back end. Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_front #(
   parameter int PRICE_WIDTH = rbb_pkg::PRICE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rbb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             q_valid,
   output logic [PRICE_WIDTH-1:0]           q_price,
   output logic [63:0]                      q_time,
   input  logic                             q_pop
);

   logic [1:0]             count_ff, count_in;
   logic                   wr_ff, wr_in;
   logic                   rd_ff, rd_in;
   logic [PRICE_WIDTH-1:0] price_ff [2];
   logic [63:0]            time_ff  [2];
   logic [63:0]            price_wide;
   logic [PRICE_WIDTH-1:0] price_m;
   logic                   push;
   logic                   pop;

   assign price_wide = {32'd0, req_tdata[31:0]};
   assign price_m    = price_wide[PRICE_WIDTH-1:0];
   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid & req_tready & (price_m != '0);
   assign pop        = q_pop & q_valid;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
      if (push) begin
         price_ff[wr_ff] <= price_m;
         time_ff[wr_ff]  <= req_tdata[95:32];
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_price = price_ff[rd_ff];
   assign q_time  = time_ff[rd_ff];

endmodule

### src/rbb_div.sv
// Renko brick builder: serial Q0.16 fraction unit, offset / size with offset < size,
// one quotient bit per cycle. Depends on rbb_pkg.
`timescale 1ns / 1ps

module rbb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [31:0]                     offset,
   input  logic [31:0]                     size,
   output logic                            done,
   output logic [rbb_pkg::FRAC_BITS-1:0]   quot
);

   logic [31:0]                   rem_ff, rem_in;
   logic [rbb_pkg::FRAC_BITS-1:0] q_ff, q_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [32:0]                   twice;
   logic                          take;

   assign twice = {rem_ff, 1'b0};
   assign take  = (twice >= {1'b0, size});

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = offset;
         q_in   = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = take ? 32'(twice - {1'b0, size}) : twice[31:0];
         q_in   = {q_ff[rbb_pkg::FRAC_BITS-2:0], take};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### src/rbb_back.sv
// Renko brick builder back end: brick decision, run and pattern state, fraction
// sequencing and the result register. Depends on rbb_pkg and rbb_div.
`timescale 1ns / 1ps

module rbb_back #(
   parameter int PRICE_WIDTH = rbb_pkg::PRICE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            brick_size,
   input  logic [15:0]            max_bricks,
   input  logic                   q_valid,
   input  logic [PRICE_WIDTH-1:0] q_price,
   input  logic [63:0]            q_time,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rbb_pkg::rsp_type       rsp_data
);

   localparam int AW = ((PRICE_WIDTH > 32) ? PRICE_WIDTH : 32) + 1;

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} state_type;

   state_type              state_ff, state_in;
   logic [PRICE_WIDTH-1:0] ref_ff, ref_in;
   logic                   started_ff, started_in;
   logic [2:0]             dirs_ff, dirs_in;
   logic [15:0]            total_ff, total_in;
   logic [15:0]            upc_ff, upc_in;
   logic [15:0]            dnc_ff, dnc_in;
   logic                   fup_ff, fup_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rbb_pkg::rsp_type       rsp_ff, rsp_in;

   logic [31:0]            bs;
   logic [AW-1:0]          price_x, ref_x, bs_x, diff_up, diff_dn, close;
   logic                   ge, le, is_up, is_dn, out_free;
   logic [2:0]             nx_dirs;
   logic [15:0]            nx_total, nx_upc, nx_dnc;
   logic [PRICE_WIDTH-1:0] nx_ref;
   logic [63:0]            ref_w, nx_ref_w, price_w;
   logic                   div_start, div_done;
   logic [15:0]            div_q;
   logic                   rsp_load;

   assign bs       = (brick_size == 32'd0) ? 32'd1 : brick_size;
   assign price_x  = AW'(q_price);
   assign ref_x    = AW'(ref_ff);
   assign bs_x     = AW'(bs);
   assign ge       = (price_x >= ref_x);
   assign le       = (ref_x >= price_x);
   assign diff_up  = price_x - ref_x;
   assign diff_dn  = ref_x - price_x;
   assign is_up    = ge & (diff_up >= bs_x);
   assign is_dn    = le & (diff_dn >= bs_x);
   assign close    = is_up ? (ref_x + bs_x) : (ref_x - bs_x);
   assign nx_ref   = close[PRICE_WIDTH-1:0];
   assign nx_dirs  = {dirs_ff[1:0], is_up};
   assign nx_total = rbb_pkg::sat_inc(total_ff, max_bricks);
   assign nx_upc   = is_up ? rbb_pkg::sat_inc(upc_ff, max_bricks) : 16'd0;
   assign nx_dnc   = is_up ? 16'd0 : rbb_pkg::sat_inc(dnc_ff, max_bricks);
   assign ref_w    = 64'(ref_ff);
   assign nx_ref_w = 64'(nx_ref);
   assign price_w  = 64'(q_price);
   assign out_free = ~rsp_valid_ff | rsp_tready;

   rbb_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .offset (ge ? diff_up[31:0] : diff_dn[31:0]),
      .size   (bs),
      .done   (div_done),
      .quot   (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      ref_in       = ref_ff;
      started_in   = started_ff;
      dirs_in      = dirs_ff;
      total_in     = total_ff;
      upc_in       = upc_ff;
      dnc_in       = dnc_ff;
      fup_in       = fup_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      // default record: nothing formed, current statistics
      rsp_in.brick_formed  = 1'b0;
      rsp_in.brick_up      = 1'b0;
      rsp_in.brick_close   = '0;
      rsp_in.brick_time    = '0;
      rsp_in.forming_up    = fup_ff;
      rsp_in.completion    = div_q;
      rsp_in.up_run        = upc_ff;
      rsp_in.down_run      = dnc_ff;
      rsp_in.up_down_up    = (total_ff >= rbb_pkg::PATTERN_MIN) && (dirs_ff == rbb_pkg::DIR_UDU);
      rsp_in.down_up_down  = (total_ff >= rbb_pkg::PATTERN_MIN) && (dirs_ff == rbb_pkg::DIR_DUD);
      rsp_in.bricks_held   = total_ff;
      rsp_in.reference_out = ref_w[31:0];

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (!started_ff) begin
                  if (out_free) begin
                     q_pop                = 1'b1;
                     started_in           = 1'b1;
                     ref_in               = q_price;
                     rsp_valid_in         = 1'b1;
                     rsp_load             = 1'b1;
                     rsp_in.forming_up    = 1'b0;
                     rsp_in.completion    = '0;
                     rsp_in.reference_out = price_w[31:0];
                  end
               end else if (is_up || is_dn) begin
                  if (out_free) begin
                     q_pop                = 1'b1;
                     ref_in               = nx_ref;
                     dirs_in              = nx_dirs;
                     total_in             = nx_total;
                     upc_in               = nx_upc;
                     dnc_in               = nx_dnc;
                     rsp_valid_in         = 1'b1;
                     rsp_load             = 1'b1;
                     rsp_in.brick_formed  = 1'b1;
                     rsp_in.brick_up      = is_up;
                     rsp_in.brick_close   = close[31:0];
                     rsp_in.brick_time    = q_time;
                     rsp_in.forming_up    = 1'b0;
                     rsp_in.completion    = '0;
                     rsp_in.up_run        = nx_upc;
                     rsp_in.down_run      = nx_dnc;
                     rsp_in.up_down_up    = (nx_total >= rbb_pkg::PATTERN_MIN) &&
                                            (nx_dirs == rbb_pkg::DIR_UDU);
                     rsp_in.down_up_down  = (nx_total >= rbb_pkg::PATTERN_MIN) &&
                                            (nx_dirs == rbb_pkg::DIR_DUD);
                     rsp_in.bricks_held   = nx_total;
                     rsp_in.reference_out = nx_ref_w[31:0];
                  end
               end else begin
                  q_pop     = 1'b1;
                  div_start = 1'b1;
                  fup_in    = (price_x > ref_x);
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_load     = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // the result register keeps its request until a new one is loaded
      if (!rsp_load) rsp_in = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_ff       <= '0;
         started_ff   <= 1'b0;
         dirs_ff      <= '0;
         total_ff     <= '0;
         upc_ff       <= '0;
         dnc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_ff       <= ref_in;
         started_ff   <= started_in;
         dirs_ff      <= dirs_in;
         total_ff     <= total_in;
         upc_ff       <= upc_in;
         dnc_ff       <= dnc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fup_ff <= fup_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

### src/rbb_checker.sv
// Renko brick builder: port-level checks on the result channel, bound to the top level.
// Depends on rbb_pkg and renko_brick_builder.
`timescale 1ns / 1ps

module rbb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rbb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp request changed while stalled");

   a_formed_flat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[97] && rsp_tdata[113:98] == 16'd0)
      else $error("formed brick reports a partial brick");

   a_unformed_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[96:0] == 97'd0)
      else $error("brick fields set without a brick");

   a_pattern_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[146] && rsp_tdata[147]))
      else $error("both alternation patterns reported");

endmodule

bind renko_brick_builder rbb_checker u_rbb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
